// ===== design/fltpw_pkg.sv =====
// shared types, codes and constants for the four-level page table walker
`default_nettype none

package fltpw_pkg;

    localparam int PHYS_MASK_HIGH_BIT_DEF = 35;
    localparam int CMD_QUEUE_DEPTH_DEF    = 4;

    localparam int ROOT_W   = 52;
    localparam int VA_W     = 48;
    localparam int ENTRY_W  = 64;
    localparam int KIND_W   = 2;
    localparam int LEVEL_W  = 3;
    localparam int ACT_W    = 3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // actions handed from front to back
    localparam logic [ACT_W-1:0] ACT_REJECT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NEXT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FAULT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DONE_1G = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DONE_2M = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DONE_4K = 3'd6;

    // walk levels
    localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_PT   = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_PD   = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 3'd4;

    localparam int PRESENT_BIT    = 0;
    localparam int LARGE_PAGE_BIT = 7;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [1:0]        idx_sel;   // level of the next entry minus one
        logic [ROOT_W-1:0] base;
        logic [VA_W-1:0]   va;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/fltpw_front.sv =====
// front end: accepts requests, tracks walk state and classifies each request
`default_nettype none

module fltpw_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           take,
    input  wire logic                           opcode,
    input  wire logic [fltpw_pkg::VA_W-1:0]     virtual_address,
    input  wire logic [fltpw_pkg::ENTRY_W-1:0]  entry_value,
    input  wire logic [fltpw_pkg::ROOT_W-1:0]   table_root,
    output fltpw_pkg::cmd_t                     cmd
);

    logic [fltpw_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [fltpw_pkg::VA_W-1:0]    va_reg, va_next;
    logic                          present;
    logic                          large_page;

    assign present    = entry_value[fltpw_pkg::PRESENT_BIT];
    assign large_page = entry_value[fltpw_pkg::LARGE_PAGE_BIT];

    always_comb
    begin
        level_next  = level_reg;
        va_next     = va_reg;
        cmd.act     = fltpw_pkg::ACT_REJECT;
        cmd.idx_sel = 2'd3;
        cmd.base    = entry_value[fltpw_pkg::ROOT_W-1:0];
        cmd.va      = va_reg;
        if (!opcode)
        begin
            if (level_reg == fltpw_pkg::LEVEL_IDLE)
            begin
                cmd.act    = fltpw_pkg::ACT_START;
                cmd.base   = {table_root[fltpw_pkg::ROOT_W-1:4], 4'b0};
                cmd.va     = virtual_address;
                va_next    = virtual_address;
                level_next = fltpw_pkg::LEVEL_PML4;
            end
        end
        else if (level_reg != fltpw_pkg::LEVEL_IDLE && level_reg <= fltpw_pkg::LEVEL_PML4)
        begin
            level_next = fltpw_pkg::LEVEL_IDLE;
            if (!present)
                cmd.act = fltpw_pkg::ACT_FAULT;
            else if (level_reg == fltpw_pkg::LEVEL_PDPT && large_page)
                cmd.act = fltpw_pkg::ACT_DONE_1G;
            else if (level_reg == fltpw_pkg::LEVEL_PD && large_page)
                cmd.act = fltpw_pkg::ACT_DONE_2M;
            else if (level_reg == fltpw_pkg::LEVEL_PT)
                cmd.act = fltpw_pkg::ACT_DONE_4K;
            else
            begin
                cmd.act     = fltpw_pkg::ACT_NEXT;
                level_next  = level_reg - 3'd1;
                // next level minus one
                cmd.idx_sel = 2'(level_reg - 3'd2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= fltpw_pkg::LEVEL_IDLE;
            va_reg    <= '0;
        end
        else if (take)
        begin
            level_reg <= level_next;
            va_reg    <= va_next;
        end
    end

    a_start_goes_top: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !opcode && level_reg == fltpw_pkg::LEVEL_IDLE)
            |=> level_reg == fltpw_pkg::LEVEL_PML4)
        else $error("start request did not begin walk at top level");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.act == fltpw_pkg::ACT_REJECT) |=> $stable(level_reg) && $stable(va_reg))
        else $error("rejected request changed walk state");

    a_next_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.act == fltpw_pkg::ACT_NEXT) |=> level_reg == $past(level_reg) - 3'd1)
        else $error("walk did not step down one level");

endmodule

`default_nettype wire

// ===== design/fltpw_cmd_queue.sv =====
// short command queue between the front end and the back end
`default_nettype none

module fltpw_cmd_queue
#(
    parameter int DEPTH = fltpw_pkg::CMD_QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr,
    input  wire fltpw_pkg::cmd_t wr_data,
    input  wire logic     rd,
    output fltpw_pkg::cmd_t rd_data,
    output logic          not_empty,
    output logic          is_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fltpw_pkg::cmd_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign rd_data   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? ((wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd ? ((rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> count_reg != '0)
        else $error("command queue read while empty");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (count_reg != FULL_CNT) || rd)
        else $error("command queue written while full");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue count lost a write");

endmodule

`default_nettype wire

// ===== design/fltpw_back.sv =====
// back end: builds entry addresses and translations into the result register
`default_nettype none

module fltpw_back
#(
    parameter int PHYS_MASK_HIGH_BIT = fltpw_pkg::PHYS_MASK_HIGH_BIT_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fltpw_pkg::cmd_t               cmd,
    input  wire logic                          cmd_valid,
    output logic                               cmd_take,
    input  wire logic                          pop,
    output logic                               out_valid,
    output logic [fltpw_pkg::KIND_W-1:0]       kind,
    output logic [fltpw_pkg::ROOT_W-1:0]       read_address,
    output logic [fltpw_pkg::ROOT_W-1:0]       phys_addr,
    output logic                               fault
);

    localparam int AW = fltpw_pkg::ROOT_W;
    localparam logic [AW:0]   MASK_WIDE = ((AW+1)'(1) << (PHYS_MASK_HIGH_BIT + 1)) - (AW+1)'(1);
    localparam logic [AW-1:0] PHYS_MASK = MASK_WIDE[AW-1:0];
    localparam logic [AW-1:0] MASK_4K   = {PHYS_MASK[AW-1:12], 12'b0};
    localparam logic [AW-1:0] MASK_2M   = {PHYS_MASK[AW-1:21], 21'b0};
    localparam logic [AW-1:0] MASK_1G   = {PHYS_MASK[AW-1:30], 30'b0};

    logic                         valid_reg;
    logic [fltpw_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [AW-1:0]                raddr_reg, raddr_next;
    logic [AW-1:0]                paddr_reg, paddr_next;
    logic                         fault_reg, fault_next;
    logic [8:0]                   idx;
    logic [AW-1:0]                frame_4k;

    assign cmd_take = cmd_valid && (!valid_reg || pop);
    assign frame_4k = cmd.base & MASK_4K;

    always_comb
    begin
        case (cmd.idx_sel)
            2'd3:    idx = cmd.va[47:39];
            2'd2:    idx = cmd.va[38:30];
            2'd1:    idx = cmd.va[29:21];
            default: idx = cmd.va[20:12];
        endcase
    end

    always_comb
    begin
        kind_next  = fltpw_pkg::KIND_REJECT;
        raddr_next = '0;
        paddr_next = '0;
        fault_next = 1'b0;
        unique case (cmd.act)
            fltpw_pkg::ACT_START:
            begin
                kind_next  = fltpw_pkg::KIND_READ;
                raddr_next = cmd.base + {40'b0, idx, 3'b0};
            end
            fltpw_pkg::ACT_NEXT:
            begin
                kind_next  = fltpw_pkg::KIND_READ;
                raddr_next = frame_4k + {40'b0, idx, 3'b0};
            end
            fltpw_pkg::ACT_FAULT:
            begin
                kind_next  = fltpw_pkg::KIND_DONE;
                fault_next = 1'b1;
            end
            fltpw_pkg::ACT_DONE_1G:
            begin
                kind_next  = fltpw_pkg::KIND_DONE;
                paddr_next = (cmd.base & MASK_1G) + {22'b0, cmd.va[29:0]};
            end
            fltpw_pkg::ACT_DONE_2M:
            begin
                kind_next  = fltpw_pkg::KIND_DONE;
                paddr_next = (cmd.base & MASK_2M) + {31'b0, cmd.va[20:0]};
            end
            fltpw_pkg::ACT_DONE_4K:
            begin
                kind_next = fltpw_pkg::KIND_DONE;
                // zero leaf frame counts as a fault
                if (frame_4k == '0)
                    fault_next = 1'b1;
                else
                    paddr_next = frame_4k + {40'b0, cmd.va[11:0]};
            end
            default:
            begin
                kind_next = fltpw_pkg::KIND_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd_take)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            kind_reg  <= kind_next;
            raddr_reg <= raddr_next;
            paddr_reg <= paddr_next;
            fault_reg <= fault_next;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign read_address = raddr_reg;
    assign phys_addr    = paddr_reg;
    assign fault        = fault_reg;

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == fltpw_pkg::KIND_READ) |-> !fault_reg && paddr_reg == '0)
        else $error("read request carries translation fields");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && fault_reg) |-> kind_reg == fltpw_pkg::KIND_DONE && paddr_reg == '0)
        else $error("faulted translation has nonzero address");

    a_done_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg != fltpw_pkg::KIND_READ) |-> raddr_reg == '0)
        else $error("non-read result carries read address");

endmodule

`default_nettype wire

// ===== design/four_level_page_table_walker.sv =====
// top level of the four-level page table walker
//
//  port group                        dir  handshake
//  opcode/virtual_address/entry_value in   push, full
//  kind/read_address/phys_addr/fault out  empty, pop
//  cfg_data (table_root)             in   cfg_write
//
//  one request per cycle while full is low: classification in the front end, address add in the back end
//  an accepted request is written into the command queue, then registered into the result
//  register when the back end takes it, which waits while an unpopped result is held
//  full rises when the command queue, four entries deep by default, fills behind a stalled result
//  reset clears the walk level, queue pointers and result valid; table_root resets to zero
`default_nettype none

module four_level_page_table_walker
#(
    parameter int PHYS_MASK_HIGH_BIT = fltpw_pkg::PHYS_MASK_HIGH_BIT_DEF,
    parameter int CMD_QUEUE_DEPTH    = fltpw_pkg::CMD_QUEUE_DEPTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [fltpw_pkg::ROOT_W-1:0]   cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           opcode,
    input  wire logic [fltpw_pkg::VA_W-1:0]     virtual_address,
    input  wire logic [fltpw_pkg::ENTRY_W-1:0]  entry_value,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [fltpw_pkg::KIND_W-1:0]        kind,
    output logic [fltpw_pkg::ROOT_W-1:0]        read_address,
    output logic [fltpw_pkg::ROOT_W-1:0]        phys_addr,
    output logic                                fault
);

    logic [fltpw_pkg::ROOT_W-1:0] table_root_reg;
    logic                         take;
    logic                         q_full;
    logic                         q_not_empty;
    logic                         q_rd;
    logic                         out_valid;
    fltpw_pkg::cmd_t              front_cmd;
    fltpw_pkg::cmd_t              head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_root_reg <= '0;
        else if (cfg_write)
            table_root_reg <= cfg_data;
    end

    assign full  = q_full;
    assign take  = push && !q_full;
    assign empty = !out_valid;

    fltpw_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .opcode          (opcode),
        .virtual_address (virtual_address),
        .entry_value     (entry_value),
        .table_root      (table_root_reg),
        .cmd             (front_cmd)
    );

    fltpw_cmd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (take),
        .wr_data   (front_cmd),
        .rd        (q_rd),
        .rd_data   (head_cmd),
        .not_empty (q_not_empty),
        .is_full   (q_full)
    );

    fltpw_back #(
        .PHYS_MASK_HIGH_BIT (PHYS_MASK_HIGH_BIT)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .cmd_valid    (q_not_empty),
        .cmd_take     (q_rd),
        .pop          (pop),
        .out_valid    (out_valid),
        .kind         (kind),
        .read_address (read_address),
        .phys_addr    (phys_addr),
        .fault        (fault)
    );

endmodule

`default_nettype wire
